### rtl/dea_pkg.sv
// Shared constants, codes and types of the directory extent allocator.
`default_nettype none

package dea_pkg;

  localparam int unsigned SectorBits  = 32;
  localparam int unsigned TypeBits    = 16;
  localparam int unsigned SlotBits    = 19;
  localparam int unsigned DirSecBits  = 16;
  localparam int unsigned AlignKbBits = 15;
  localparam int unsigned UnitBits    = AlignKbBits + 2;
  localparam int unsigned SlotsShift  = 3;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned DivCntBits  = $clog2(SectorBits);

  localparam logic [CfgIdxBits-1:0] CfgDirStart   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgDirSectors = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgLastSector = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgRequest    = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgAlignEn    = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgAlignKb    = 3'd5;
  localparam logic [CfgIdxBits-1:0] CfgEndCode    = 3'd6;

  localparam logic ReqBegin = 1'b0;

  localparam logic [SectorBits-1:0]  DirStartRst   = SectorBits'(2);
  localparam logic [DirSecBits-1:0]  DirSectorsRst = DirSecBits'(1);
  localparam logic [SectorBits-1:0]  LastSectorRst = '0;
  localparam logic [SectorBits-1:0]  RequestRst    = '0;
  localparam logic                   AlignEnRst    = 1'b0;
  localparam logic [AlignKbBits-1:0] AlignKbRst    = AlignKbBits'(1);
  localparam logic [TypeBits-1:0]    EndCodeRst    = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PHYS,
    ST_SETTLE,
    ST_SETTLE_END,
    ST_GRANT,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } dea_state_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_GRANT,
    EV_PHYS,
    EV_SETTLE_END
  } dea_ev_e;

  typedef struct packed {
    logic cap;
    logic eval;
    logic phys;
    logic refuse;
    logic grant;
    logic grant_end;
    logic div_step;
    logic fix;
    logic load;
  } dea_cmd_t;

  typedef struct packed {
    dea_ev_e ev_kind;
    logic    phys_refuse;
    logic    settle_refuse;
    logic    align_on;
    logic    div_last;
    logic    out_free;
  } dea_sts_t;

endpackage

`default_nettype wire

### rtl/dea_ctrl.sv
// Controller state machine that sequences scan, decision, alignment and output.
`default_nettype none

module dea_ctrl
  import dea_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dea_sts_t sts_i,
  output dea_cmd_t cmd_o
);

  dea_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        case (sts_i.ev_kind)
          EV_NONE:       state_d = ST_IDLE;
          EV_GRANT:      state_d = ST_GRANT;
          EV_PHYS:       state_d = ST_PHYS;
          EV_SETTLE_END: state_d = ST_SETTLE_END;
          default:       state_d = ST_IDLE;
        endcase
      end
      ST_PHYS: begin
        if (sts_i.phys_refuse) begin
          cmd_o.refuse = 1'b1;
          state_d      = ST_OUT;
        end else begin
          cmd_o.phys = 1'b1;
          state_d    = ST_SETTLE;
        end
      end
      ST_SETTLE, ST_SETTLE_END: begin
        if (sts_i.settle_refuse) begin
          cmd_o.refuse = 1'b1;
          state_d      = ST_OUT;
        end else begin
          cmd_o.grant     = 1'b1;
          cmd_o.grant_end = (state_q == ST_SETTLE_END);
          state_d         = sts_i.align_on ? ST_DIV : ST_OUT;
        end
      end
      ST_GRANT: begin
        cmd_o.grant = 1'b1;
        state_d     = sts_i.align_on ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/dea_dpath.sv
// Datapath: configuration, scan state, gap compare, alignment remainder and output register.
`default_nettype none

module dea_dpath
  import dea_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dea_cmd_t               cmd_i,
  output dea_sts_t               sts_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   req_type_i,
  input  logic [TypeBits-1:0]    entry_type_i,
  input  logic [SectorBits-1:0]  entry_start_i,
  input  logic [SectorBits-1:0]  entry_size_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   granted_o,
  output logic [SectorBits-1:0]  alloc_start_o,
  output logic [SectorBits-1:0]  alloc_size_o,
  output logic [SlotBits-1:0]    slot_index_o,
  output logic                   move_end_marker_o
);

  logic [SectorBits-1:0]  dir_start_q, last_sector_q, request_q;
  logic [DirSecBits-1:0]  dir_sectors_q;
  logic                   align_en_q;
  logic [AlignKbBits-1:0] align_kb_q;
  logic [TypeBits-1:0]    end_code_q;

  logic                  req_q;
  logic [TypeBits-1:0]   type_q;
  logic [SectorBits-1:0] start_q, size_q;

  logic [SectorBits-1:0] last_used_q, last_used_d;
  logic                  open_valid_q, open_valid_d;
  logic [SlotBits-1:0]   open_slot_q, open_slot_d;
  logic [SectorBits-1:0] best_gap_q, best_gap_d;
  logic [SlotBits-1:0]   best_slot_q, best_slot_d;
  logic [SectorBits-1:0] best_after_q, best_after_d;
  logic [SlotBits-1:0]   slot_q, slot_d;
  logic                  scan_done_q, scan_done_d;

  logic                  res_granted_q, res_move_q;
  logic [SectorBits-1:0] res_start_q, res_size_q;
  logic [SlotBits-1:0]   res_slot_q;
  logic [SectorBits-1:0] div_sh_q;
  logic [UnitBits-1:0]   rem_q;
  logic [DivCntBits-1:0] div_cnt_q;

  logic                  out_valid_q;
  logic                  out_granted_q, out_move_q;
  logic [SectorBits-1:0] out_start_q, out_size_q;
  logic [SlotBits-1:0]   out_slot_q;

  logic [SlotBits-1:0]     total;
  logic                    fixed;
  logic [UnitBits-1:0]     unit;
  logic                    align_on;
  logic                    at_phys0, inc_phys;
  logic [SlotBits-1:0]     cnt_inc, new_os;
  logic [SectorBits+1:0]   ent_gap;
  logic                    ent_better, ent_fit, ent_grant;
  logic [SectorBits:0]     end_gap;
  logic                    end_better;
  logic                    is_end, is_purged;
  dea_ev_e                 ev_kind;
  logic [SectorBits-1:0]   s0, s_clamp;
  logic                    move;
  logic [UnitBits:0]       trial;
  logic [UnitBits-1:0]     pad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_start_q   <= DirStartRst;
      dir_sectors_q <= DirSectorsRst;
      last_sector_q <= LastSectorRst;
      request_q     <= RequestRst;
      align_en_q    <= AlignEnRst;
      align_kb_q    <= AlignKbRst;
      end_code_q    <= EndCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDirStart:   dir_start_q   <= cfg_data_i[SectorBits-1:0];
        CfgDirSectors: dir_sectors_q <= cfg_data_i[DirSecBits-1:0];
        CfgLastSector: last_sector_q <= cfg_data_i[SectorBits-1:0];
        CfgRequest:    request_q     <= cfg_data_i[SectorBits-1:0];
        CfgAlignEn:    align_en_q    <= cfg_data_i[0];
        CfgAlignKb:    align_kb_q    <= cfg_data_i[AlignKbBits-1:0];
        CfgEndCode:    end_code_q    <= cfg_data_i[TypeBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q   <= req_type_i;
      type_q  <= entry_type_i;
      start_q <= entry_start_i;
      size_q  <= entry_size_i;
    end
  end

  assign total     = {dir_sectors_q, {SlotsShift{1'b0}}};
  assign fixed     = (request_q != '0);
  assign unit      = {align_kb_q, 2'b00};
  assign align_on  = align_en_q && (align_kb_q != '0);
  assign at_phys0  = (slot_q >= total);
  assign cnt_inc   = slot_q + SlotBits'(1);
  assign inc_phys  = (cnt_inc >= total);
  assign new_os    = open_valid_q ? open_slot_q : slot_q;
  assign is_end    = (type_q == end_code_q);
  assign is_purged = (type_q == '0);

  // A file entry closes the open gap; a negative gap never wins.
  assign ent_gap    = {2'b00, start_q} - {2'b00, last_used_q} - (SectorBits+2)'(1);
  assign ent_better = !ent_gap[SectorBits+1] && (ent_gap[SectorBits:0] > {1'b0, best_gap_q});
  assign ent_fit    = fixed && (ent_gap[SectorBits:0] >= {1'b0, request_q});
  assign ent_grant  = open_valid_q && ent_better && ent_fit;

  assign end_gap    = {1'b0, last_sector_q} - {1'b0, last_used_q};
  assign end_better = !end_gap[SectorBits] && (end_gap[SectorBits-1:0] > best_gap_q);

  always_comb begin
    ev_kind = EV_NONE;
    if (req_q == ReqBegin || scan_done_q) begin
      ev_kind = EV_NONE;
    end else if (at_phys0) begin
      ev_kind = EV_PHYS;
    end else if (is_end) begin
      ev_kind = EV_SETTLE_END;
    end else if (is_purged) begin
      ev_kind = inc_phys ? EV_PHYS : EV_NONE;
    end else if (ent_grant) begin
      ev_kind = EV_GRANT;
    end else begin
      ev_kind = inc_phys ? EV_PHYS : EV_NONE;
    end
  end

  always_comb begin
    last_used_d  = last_used_q;
    open_valid_d = open_valid_q;
    open_slot_d  = open_slot_q;
    best_gap_d   = best_gap_q;
    best_slot_d  = best_slot_q;
    best_after_d = best_after_q;
    slot_d       = slot_q;
    scan_done_d  = scan_done_q;
    if (cmd_i.eval) begin
      if (req_q == ReqBegin) begin
        last_used_d  = dir_start_q + SectorBits'(dir_sectors_q) - SectorBits'(1);
        open_valid_d = 1'b0;
        open_slot_d  = '0;
        best_gap_d   = '0;
        best_slot_d  = '0;
        best_after_d = '0;
        slot_d       = '0;
        scan_done_d  = 1'b0;
      end else if (!scan_done_q && !at_phys0) begin
        if (is_end) begin
          open_valid_d = 1'b1;
          open_slot_d  = new_os;
          if (end_better) begin
            best_gap_d   = end_gap[SectorBits-1:0];
            best_slot_d  = new_os;
            best_after_d = last_used_q;
          end
        end else if (is_purged) begin
          open_valid_d = 1'b1;
          open_slot_d  = new_os;
          slot_d       = cnt_inc;
        end else begin
          if (open_valid_q && ent_better) begin
            best_gap_d   = ent_gap[SectorBits-1:0];
            best_slot_d  = open_slot_q;
            best_after_d = last_used_q;
          end
          if (!ent_grant) begin
            open_valid_d = 1'b0;
            last_used_d  = start_q + size_q - SectorBits'(1);
            slot_d       = cnt_inc;
          end
        end
      end
    end
    // Past the last slot the space after the last file counts as a gap.
    if (cmd_i.phys && open_valid_q && end_better) begin
      best_gap_d   = end_gap[SectorBits-1:0];
      best_slot_d  = open_slot_q;
      best_after_d = last_used_q;
    end
    if (cmd_i.refuse || cmd_i.grant) begin
      scan_done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_used_q  <= '0;
      open_valid_q <= 1'b0;
      open_slot_q  <= '0;
      best_gap_q   <= '0;
      best_slot_q  <= '0;
      best_after_q <= '0;
      slot_q       <= '0;
      scan_done_q  <= 1'b1;
    end else begin
      last_used_q  <= last_used_d;
      open_valid_q <= open_valid_d;
      open_slot_q  <= open_slot_d;
      best_gap_q   <= best_gap_d;
      best_slot_q  <= best_slot_d;
      best_after_q <= best_after_d;
      slot_q       <= slot_d;
      scan_done_q  <= scan_done_d;
    end
  end

  assign s0      = best_after_q + SectorBits'(1);
  assign s_clamp = (align_on && (s0 < SectorBits'(unit))) ? SectorBits'(unit) : s0;
  assign move    = cmd_i.grant_end && (best_slot_q == slot_q) &&
                   (({1'b0, best_slot_q} + (SlotBits+1)'(1)) < {1'b0, total});
  assign trial   = {rem_q, div_sh_q[SectorBits-1]};
  assign pad     = unit - rem_q;

  // The remainder of the start by the alignment is found one bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.refuse) begin
      res_granted_q <= 1'b0;
      res_start_q   <= '0;
      res_size_q    <= '0;
      res_slot_q    <= '0;
      res_move_q    <= 1'b0;
    end else if (cmd_i.grant) begin
      res_granted_q <= 1'b1;
      res_start_q   <= s_clamp;
      res_size_q    <= fixed ? request_q : best_gap_q;
      res_slot_q    <= best_slot_q;
      res_move_q    <= move;
      div_sh_q      <= s_clamp;
      rem_q         <= '0;
    end else if (cmd_i.div_step) begin
      rem_q    <= (trial >= {1'b0, unit}) ? UnitBits'(trial - {1'b0, unit})
                                          : trial[UnitBits-1:0];
      div_sh_q <= {div_sh_q[SectorBits-2:0], 1'b0};
    end else if (cmd_i.fix) begin
      if (rem_q != '0) begin
        res_start_q <= res_start_q + SectorBits'(pad);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.grant) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DivCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_granted_q <= res_granted_q;
      out_start_q   <= res_start_q;
      out_size_q    <= res_size_q;
      out_slot_q    <= res_slot_q;
      out_move_q    <= res_move_q;
    end
  end

  assign sts_o.ev_kind       = ev_kind;
  assign sts_o.phys_refuse   = !open_valid_q && fixed;
  assign sts_o.settle_refuse = (best_gap_q == '0) || (fixed && (best_gap_q < request_q));
  assign sts_o.align_on      = align_on;
  assign sts_o.div_last      = (div_cnt_q == DivCntBits'(SectorBits - 1));
  assign sts_o.out_free      = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign granted_o         = out_granted_q;
  assign alloc_start_o     = out_start_q;
  assign alloc_size_o      = out_size_q;
  assign slot_index_o      = out_slot_q;
  assign move_end_marker_o = out_move_q;

endmodule

`default_nettype wire

### rtl/directory_extent_allocator_core.sv
// Each directory entry beat is first captured and then evaluated.
// A decision passes through the last-slot and settle steps as needed, then one output load.
// With alignment on, the start remainder is found one bit per cycle, followed by a fix step.
// A finished result waits in an output register while the next entry is taken in.
// Reset is asynchronous and active low; it restores the register defaults and leaves the
// scan done, so entries are ignored until a begin beat arrives.
`default_nettype none

module directory_extent_allocator_core
  import dea_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [TypeBits-1:0]    entry_type_i,
  input  logic [SectorBits-1:0]  entry_start_i,
  input  logic [SectorBits-1:0]  entry_size_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   granted_o,
  output logic [SectorBits-1:0]  alloc_start_o,
  output logic [SectorBits-1:0]  alloc_size_o,
  output logic [SlotBits-1:0]    slot_index_o,
  output logic                   move_end_marker_o
);

  dea_cmd_t cmd;
  dea_sts_t sts;

  dea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dea_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .req_type_i        (req_type_i),
    .entry_type_i      (entry_type_i),
    .entry_start_i     (entry_start_i),
    .entry_size_i      (entry_size_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_o         (granted_o),
    .alloc_start_o     (alloc_start_o),
    .alloc_size_o      (alloc_size_o),
    .slot_index_o      (slot_index_o),
    .move_end_marker_o (move_end_marker_o)
  );

endmodule

`default_nettype wire

### verif/tb_directory_extent_allocator_core.sv
// Self-checking testbench of the directory extent allocator core with its own scan predictor.
module tb_directory_extent_allocator_core;
  import dea_pkg::*;

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic                  granted;
    logic [SectorBits-1:0] start_sec;
    logic [SectorBits-1:0] sectors;
    logic [SlotBits-1:0]   slot;
    logic                  move_end;
  } alloc_result_t;

  typedef enum logic [1:0] {
    StallNone,
    StallHalf,
    StallRare,
    StallHeavy
  } stall_mode_e;

  localparam logic        ReqEntry     = ~ReqBegin;
  localparam u64_t        SectorMask   = (64'd1 << SectorBits) - 64'd1;
  localparam u64_t        SlotMask     = (64'd1 << SlotBits) - 64'd1;
  localparam int unsigned SectorsPerKb = 4;
  localparam int unsigned ItemGoal     = 1800;
  localparam int unsigned QuietCycles  = 80;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned HoldCycles   = 800;
  localparam int unsigned CycleLimit   = 1000000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_index_i   = '0;
  logic [CfgDataBits-1:0] cfg_data_i    = '0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic                   req_type_i    = ReqBegin;
  logic [TypeBits-1:0]    entry_type_i  = '0;
  logic [SectorBits-1:0]  entry_start_i = '0;
  logic [SectorBits-1:0]  entry_size_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i   = 1'b0;
  logic                   granted_o;
  logic [SectorBits-1:0]  alloc_start_o;
  logic [SectorBits-1:0]  alloc_size_o;
  logic [SlotBits-1:0]    slot_index_o;
  logic                   move_end_marker_o;

  directory_extent_allocator_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .entry_type_i      (entry_type_i),
    .entry_start_i     (entry_start_i),
    .entry_size_i      (entry_size_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_o         (granted_o),
    .alloc_start_o     (alloc_start_o),
    .alloc_size_o      (alloc_size_o),
    .slot_index_o      (slot_index_o),
    .move_end_marker_o (move_end_marker_o)
  );

  always #1 clk_i = ~clk_i;

  u64_t cfg_dir_start   = 2;
  u64_t cfg_dir_sectors = 1;
  u64_t cfg_last_sector = 0;
  u64_t cfg_request     = 0;
  u64_t cfg_align_en    = 0;
  u64_t cfg_align_kb    = 1;
  u64_t cfg_end_code    = 16'hFFFF;

  u64_t used_end   = 0;
  bit   run_open   = 1'b0;
  u64_t run_slot   = 0;
  u64_t wide_gap   = 0;
  u64_t wide_slot  = 0;
  u64_t wide_after = 0;
  u64_t slot_no    = 0;
  bit   scan_idle  = 1'b1;

  alloc_result_t verdict;
  alloc_result_t want_alloc;
  alloc_result_t expected_allocs[$];

  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;

  logic        hold_go    = 1'b0;
  logic        hold_ack   = 1'b0;
  int unsigned hold_left  = 0;
  stall_mode_e stall_mode = StallNone;
  int unsigned mode_left  = 0;

  function automatic void weigh_gap(longint gap, u64_t after);
    if (gap > longint'(wide_gap)) begin
      wide_gap   = u64_t'(gap);
      wide_slot  = run_slot;
      wide_after = after;
    end
  endfunction

  function automatic bit refuse_alloc();
    verdict   = '0;
    scan_idle = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit grant_alloc(bit at_end);
    u64_t first;
    u64_t unit;
    u64_t total;
    total = cfg_dir_sectors << SlotsShift;
    first = (wide_after + 1) & SectorMask;
    unit  = cfg_align_kb * SectorsPerKb;
    if (cfg_align_en != 0 && unit != 0) begin
      if (first < unit) first = unit;
      if (first % unit != 0) first = (first + (unit - first % unit)) & SectorMask;
    end
    verdict.granted   = 1'b1;
    verdict.start_sec = first[SectorBits-1:0];
    verdict.sectors   = SectorBits'((cfg_request != 0) ? cfg_request : wide_gap);
    verdict.slot      = wide_slot[SlotBits-1:0];
    verdict.move_end  = at_end && (wide_slot + 1 < total);
    scan_idle         = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit settle_scan(bit at_end);
    if (wide_gap == 0 || (cfg_request != 0 && wide_gap < cfg_request)) return refuse_alloc();
    return grant_alloc(at_end && wide_slot == slot_no);
  endfunction

  function automatic bit reach_dir_end();
    if (!run_open && cfg_request != 0) return refuse_alloc();
    if (run_open) weigh_gap(longint'(cfg_last_sector) - longint'(used_end), used_end);
    return settle_scan(1'b0);
  endfunction

  // Returns one when the beat settles the scan; the outcome is left in verdict.
  function automatic bit scan_step(logic rt, logic [TypeBits-1:0] kind,
                                   logic [SectorBits-1:0] st, logic [SectorBits-1:0] sz);
    u64_t   total;
    u64_t   first;
    u64_t   len;
    longint gap;
    total = cfg_dir_sectors << SlotsShift;
    first = u64_t'(st);
    len   = u64_t'(sz);
    if (rt == ReqBegin) begin
      used_end   = (cfg_dir_start + cfg_dir_sectors - 1) & SectorMask;
      run_open   = 1'b0;
      run_slot   = 0;
      wide_gap   = 0;
      wide_slot  = 0;
      wide_after = 0;
      slot_no    = 0;
      scan_idle  = 1'b0;
      return 1'b0;
    end
    if (scan_idle) return 1'b0;
    if (slot_no >= total) return reach_dir_end();
    if (u64_t'(kind) == cfg_end_code) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_slot = slot_no;
      end
      weigh_gap(longint'(cfg_last_sector) - longint'(used_end), used_end);
      return settle_scan(1'b1);
    end else if (kind == 0) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_slot = slot_no;
      end
    end else begin
      if (run_open) begin
        gap = longint'(first) - longint'(used_end) - 1;
        if (gap > longint'(wide_gap)) begin
          weigh_gap(gap, used_end);
          if (cfg_request != 0 && wide_gap >= cfg_request) return grant_alloc(1'b0);
        end
      end
      run_open = 1'b0;
      used_end = (first + len - 1) & SectorMask;
    end
    slot_no = (slot_no + 1) & SlotMask;
    if (slot_no >= total) return reach_dir_end();
    return 1'b0;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task automatic compare_field(string name, u64_t got, u64_t want);
    if (got !== want) begin
      flag_error($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_allocs.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no decision pending", results_seen));
      end else begin
        want_alloc = expected_allocs.pop_front();
        compare_field("granted", granted_o, want_alloc.granted);
        compare_field("alloc_start", alloc_start_o, want_alloc.start_sec);
        compare_field("alloc_size", alloc_size_o, want_alloc.sectors);
        compare_field("slot_index", slot_index_o, want_alloc.slot);
        compare_field("move_end_marker", move_end_marker_o, want_alloc.move_end);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (hold_go != hold_ack) begin
      hold_ack    <= hold_go;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        StallNone:  out_stall_i <= 1'b0;
        StallHalf:  out_stall_i <= $urandom_range(0, 1) == 0;
        StallRare:  out_stall_i <= $urandom_range(0, 7) == 0;
        default:    out_stall_i <= $urandom_range(0, 3) != 0;
      endcase
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_beat(logic rt, logic [TypeBits-1:0] kind,
                           logic [SectorBits-1:0] st, logic [SectorBits-1:0] sz);
    int unsigned gap_cycles;
    if (burst_left == 0) begin
      gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_cycles != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_cycles) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rt;
    entry_type_i  <= kind;
    entry_start_i <= st;
    entry_size_i  <= sz;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (scan_step(rt, kind, st, sz)) expected_allocs.push_back(verdict);
    burst_left--;
    items_sent++;
  endtask

  // Entries that settle nothing may still be in flight after the last result.
  task automatic drain_allocs();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_allocs.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CfgDirStart:   cfg_dir_start   = u64_t'(data);
      CfgDirSectors: cfg_dir_sectors = u64_t'(data[DirSecBits-1:0]);
      CfgLastSector: cfg_last_sector = u64_t'(data);
      CfgRequest:    cfg_request     = u64_t'(data);
      CfgAlignEn:    cfg_align_en    = u64_t'(data[0]);
      CfgAlignKb:    cfg_align_kb    = u64_t'(data[AlignKbBits-1:0]);
      CfgEndCode:    cfg_end_code    = u64_t'(data[TypeBits-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_setup(logic [31:0] base, logic [31:0] dirs, logic [31:0] last,
                             logic [31:0] req, logic [31:0] align_on, logic [31:0] kb,
                             logic [31:0] code);
    put_reg(CfgDirStart, base);
    put_reg(CfgDirSectors, dirs);
    put_reg(CfgLastSector, last);
    put_reg(CfgRequest, req);
    put_reg(CfgAlignEn, align_on);
    put_reg(CfgAlignKb, kb);
    put_reg(CfgEndCode, code);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_beat(ReqEntry, 16'h1234, 32'd5, 32'd5);
    send_beat(ReqBegin, '0, '0, '0);
    send_beat(ReqEntry, '0, '0, '0);
    send_beat(ReqEntry, 16'h0001, 32'd10, 32'd5);
    send_beat(ReqEntry, EndCodeRst, '1, '1);
    send_beat(ReqEntry, 16'h0001, '1, '1);
  endtask

  task automatic test_first_fit();
    drain_allocs();
    apply_setup(32'd100, 32'd1, '1, 32'd4, 32'd0, 32'd1, 32'hFFFF);
    send_beat(ReqBegin, '1, '1, '1);
    send_beat(ReqEntry, '0, '0, '0);
    send_beat(ReqEntry, 16'hFFFE, 32'd106, '1);
    send_beat(ReqBegin, '0, '0, '0);
    send_beat(ReqEntry, '0, '0, '0);
    send_beat(ReqEntry, 16'h0001, 32'd103, 32'd2);
    send_beat(ReqEntry, 16'h8000, 32'd96, 32'd1);
    send_beat(ReqEntry, 16'hFFFF, '0, '0);
  endtask

  task automatic test_end_marker_max_dir();
    drain_allocs();
    apply_setup(32'd40, 32'hFFFF, '1, 32'd0, 32'd0, 32'd1, 32'd0);
    send_beat(ReqBegin, '0, '0, '0);
    send_beat(ReqEntry, '0, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_directory_end();
    drain_allocs();
    apply_setup(32'd0, 32'd1, 32'd300, 32'd0, 32'd1, 32'd0, 32'hFFFF);
    send_beat(ReqBegin, '0, '0, '0);
    send_beat(ReqEntry, 16'h0002, 32'd1, 32'd4);
    repeat (7) send_beat(ReqEntry, '0, '0, '0);
    drain_allocs();
    apply_setup(32'd0, 32'd0, 32'd300, 32'd1, 32'd0, 32'd1, 32'hFFFF);
    send_beat(ReqBegin, '0, '0, '0);
    send_beat(ReqEntry, '0, '0, '0);
  endtask

  task automatic test_alignment_wrap();
    drain_allocs();
    apply_setup(32'hFFFF_FFFE, 32'd1, '1, 32'd0, 32'd1, 32'd16384, 32'hFFFF);
    send_beat(ReqBegin, '0, '0, '0);
    send_beat(ReqEntry, 16'hFFFF, '0, '0);
  endtask

  task automatic test_long_holdoff();
    drain_allocs();
    apply_setup(32'd10, 32'd1, 32'd4000, 32'd0, 32'd1, 32'd3, 32'hFFFF);
    hold_go <= ~hold_go;
    repeat (20) begin
      send_beat(ReqBegin, TypeBits'($urandom()), $urandom(), $urandom());
      send_beat(ReqEntry, '0, $urandom(), $urandom());
      send_beat(ReqEntry, 16'hFFFF, $urandom(), $urandom());
    end
    drain_allocs();
  endtask

  task automatic random_setup();
    logic [31:0] base;
    logic [31:0] dirs;
    logic [31:0] last;
    logic [31:0] req;
    logic [31:0] kb;
    logic [31:0] code;
    case ($urandom_range(0, 9))
      0:       dirs = 0;
      1:       dirs = 32'hFFFF;
      2, 3:    dirs = $urandom_range(2, 4);
      default: dirs = 1;
    endcase
    base = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 5000);
    case ($urandom_range(0, 5))
      0:       last = $urandom();
      1:       last = '1;
      2:       last = '0;
      default: last = base + dirs + $urandom_range(0, 2000);
    endcase
    case ($urandom_range(0, 7))
      0:       req = '1;
      1:       req = $urandom();
      2, 3, 4: req = $urandom_range(1, 40);
      default: req = '0;
    endcase
    case ($urandom_range(0, 5))
      0:       kb = 0;
      1:       kb = 16384;
      2:       kb = 32'h7FFF;
      default: kb = $urandom_range(1, 64);
    endcase
    case ($urandom_range(0, 5))
      0:       code = 0;
      1:       code = $urandom_range(1, 65534);
      default: code = 32'hFFFF;
    endcase
    apply_setup(base, dirs, last, req, $urandom_range(0, 1), kb, code);
  endtask

  task automatic random_scan();
    logic [SectorBits-1:0] cursor;
    logic [SectorBits-1:0] st;
    logic [SectorBits-1:0] sz;
    logic [TypeBits-1:0]   kind;
    int unsigned           n;
    int unsigned           end_at;
    int unsigned           roll;
    if ($urandom_range(0, 9) == 0) begin
      send_beat(ReqEntry, TypeBits'($urandom()), $urandom(), $urandom());
    end
    send_beat(ReqBegin, TypeBits'($urandom()), $urandom(), $urandom());
    if (cfg_dir_sectors == 0) n = 2;
    else if (cfg_dir_sectors > 3) n = $urandom_range(1, 14);
    else n = $urandom_range(1, 32'(cfg_dir_sectors) * 8 + 2);
    end_at = $urandom_range(0, n + n / 2);
    cursor = SectorBits'(cfg_dir_start + cfg_dir_sectors);
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (i == end_at) begin
        kind = cfg_end_code[TypeBits-1:0];
        st   = $urandom();
        sz   = $urandom();
      end else if (roll < 25) begin
        kind = '0;
        st   = $urandom();
        sz   = $urandom();
      end else if (roll < 33) begin
        kind = TypeBits'($urandom());
        st   = $urandom();
        sz   = $urandom();
      end else begin
        do kind = TypeBits'($urandom()); while (kind == 0 || kind == cfg_end_code);
        if (roll < 38) st = cursor - $urandom_range(1, 40);
        else if (roll < 55) st = cursor;
        else st = cursor + $urandom_range(1, 40);
        sz     = $urandom_range(1, 60);
        cursor = st + sz;
      end
      send_beat(ReqEntry, kind, st, sz);
      if (i == end_at) break;
    end
  endtask

  task automatic test_random_scans();
    int unsigned first_item;
    first_item = items_sent;
    while (items_sent - first_item < ItemGoal) begin
      drain_allocs();
      random_setup();
      repeat ($urandom_range(3, 12)) random_scan();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_first_fit();
    test_end_marker_max_dir();
    test_directory_end();
    test_alignment_wrap();
    test_long_holdoff();
    test_random_scans();
    drain_allocs();
    if (expected_allocs.size() != 0) begin
      flag_error($sformatf("%0d decisions never produced a result", expected_allocs.size()));
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
